/* rtl/heq_pkg.sv */
// Shared types and constants for the three-channel histogram equalizer.
// No dependencies; imported by heq_scale and the top level.
package heq_pkg;

   localparam int CHANNEL_COUNT = 3;
   localparam int BIN_COUNT     = 256;
   localparam int BIN_BITS      = 8;
   localparam int COUNT_BITS    = 24;
   localparam int SAMPLE_BITS   = 8;
   localparam int CH_BITS       = 2;
   localparam int NUM_BITS      = COUNT_BITS + 8;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [BIN_BITS-1:0]   BIN_LAST  = BIN_BITS'(BIN_COUNT - 1);
   localparam logic [CH_BITS-1:0]    CH_LAST   = CH_BITS'(CHANNEL_COUNT - 1);

   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_COUNT    = 2'd1,
      CMD_FINALIZE = 2'd2,
      CMD_MAP      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_READY = 2'd1,
      STS_FULL      = 2'd2,
      STS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_MAP_RD,
      ST_MAP_OUT,
      ST_FIN_RD,
      ST_FIN_ACC,
      ST_FIN_DIV
   } state_type;

endpackage

/* rtl/heq_scale.sv */
// Iterative scale unit: round(cum * 255 / total), ties to even, one quotient bit a cycle.
// Depends on heq_pkg. Requires cum <= total and total != 0.
module heq_scale
   import heq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COUNT_BITS-1:0] cum,
   input  logic [COUNT_BITS-1:0] total,
   output logic                  done,
   output logic [7:0]            result
);

   logic [NUM_BITS-1:0] rem_ff, rem_in;
   logic [7:0]          quo_ff, quo_in;
   logic [2:0]          step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [NUM_BITS-1:0] dvs;
   logic [COUNT_BITS+1:0] twice;
   logic                inc;

   assign dvs = NUM_BITS'(total) << step_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // cum * 255 as (cum << 8) - cum
         rem_in  = {cum, 8'd0} - NUM_BITS'(cum);
         quo_in  = 8'd0;
         step_in = 3'd7;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dvs) begin
            rem_in          = rem_ff - dvs;
            quo_in[step_ff] = 1'b1;
         end
         step_in = step_ff - 3'd1;
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // remainder is below total here, so it fits COUNT_BITS
   assign twice  = {1'b0, rem_ff[COUNT_BITS-1:0], 1'b0};
   assign inc    = (twice > (COUNT_BITS+2)'(total)) ||
                   ((twice == (COUNT_BITS+2)'(total)) && quo_ff[0]);
   assign result = (inc && (quo_ff != 8'hFF)) ? quo_ff + 8'd1 : quo_ff;
   assign done   = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("scale start while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff) else $error("scale done without work");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("scale did not start");

endmodule

/* rtl/histogram_equalizer_three_channel.sv */
// Top level of the three-channel histogram equalizer: sequencer, bin and map memories.
// Depends on heq_pkg and heq_scale.
//
// One request word is taken at a time and always yields exactly one response word.
// Count steps through read, increment-write and respond, and map through read and respond;
// either answers directly from idle when it ends in an error status. Clear sweeps all
// 256 bin addresses of every channel in parallel. Finalize walks 3 x 256 bins; each bin
// goes through read, accumulate, the 8-step shared divider, and round and store, with the
// divide done by the single iterative scale unit. After reset the block runs the same
// clearing pass over all 256 addresses with req_stall high
// and gives no response for it. The response register holds a word until the
// consumer takes it; no new request is taken while a response is pending.
module histogram_equalizer_three_channel
   import heq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  logic [SAMPLE_BITS-1:0] req_ch0_value,
   input  logic [SAMPLE_BITS-1:0] req_ch1_value,
   input  logic [SAMPLE_BITS-1:0] req_ch2_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_ch0_mapped,
   output logic [7:0]             rsp_ch1_mapped,
   output logic [7:0]             rsp_ch2_mapped,
   output logic [1:0]             rsp_status
);

   state_type             state_ff, state_in;
   logic [BIN_BITS-1:0]   idx_ff, idx_in;
   logic [CH_BITS-1:0]    ch_ff, ch_in;
   logic [COUNT_BITS-1:0] sum_ff, sum_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  ready_ff, ready_in;
   logic                  clr_rsp_ff, clr_rsp_in;
   logic [BIN_BITS-1:0]   smp_ff [CHANNEL_COUNT];
   logic [BIN_BITS-1:0]   smp_in [CHANNEL_COUNT];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_map_ff [CHANNEL_COUNT];
   logic [7:0]            rsp_map_in [CHANNEL_COUNT];
   logic [1:0]            rsp_status_ff, rsp_status_in;

   // Histograms and tables, one memory row per bin index across all channels
   logic [COUNT_BITS-1:0] bin_mem    [CHANNEL_COUNT][BIN_COUNT];
   logic [7:0]            map_mem    [CHANNEL_COUNT][BIN_COUNT];
   logic [COUNT_BITS-1:0] bin_rd_ff  [CHANNEL_COUNT];
   logic [7:0]            map_rd_ff  [CHANNEL_COUNT];
   logic [BIN_BITS-1:0]   rd_addr    [CHANNEL_COUNT];
   logic [BIN_BITS-1:0]   wr_addr    [CHANNEL_COUNT];
   logic                  bin_we     [CHANNEL_COUNT];
   logic                  map_we     [CHANNEL_COUNT];
   logic [COUNT_BITS-1:0] bin_wd     [CHANNEL_COUNT];
   logic [7:0]            map_wd;

   logic                  accept;
   logic                  div_start;
   logic                  div_done;
   logic [7:0]            div_q;
   cmd_type               req_cmd;

   assign req_cmd   = cmd_type'(req_command);
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;

   heq_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .cum    (sum_in),
      .total  (total_ff),
      .done   (div_done),
      .result (div_q)
   );

   // Sequencer: next state, datapath updates and memory controls
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      ch_in         = ch_ff;
      sum_in        = sum_ff;
      total_in      = total_ff;
      ready_in      = ready_ff;
      clr_rsp_in    = clr_rsp_ff;
      smp_in        = smp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_map_in    = rsp_map_ff;
      rsp_status_in = rsp_status_ff;
      div_start     = 1'b0;
      map_wd        = div_q;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         rd_addr[c] = ((state_ff == ST_CNT_RD) || (state_ff == ST_MAP_RD)) ?
                      smp_ff[c] : idx_ff;
         wr_addr[c] = (state_ff == ST_CNT_WR) ? smp_ff[c] : idx_ff;
         bin_we[c]  = 1'b0;
         map_we[c]  = 1'b0;
         bin_wd[c]  = bin_rd_ff[c] + COUNT_BITS'(1);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
               bin_we[c] = 1'b1;
               map_we[c] = 1'b1;
               bin_wd[c] = '0;
            end
            map_wd = 8'd0;
            idx_in = idx_ff + BIN_BITS'(1);
            if (idx_ff == BIN_LAST) begin
               state_in = ST_IDLE;
               if (clr_rsp_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STS_OK;
               end
               clr_rsp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               smp_in[0] = req_ch0_value;
               smp_in[1] = req_ch1_value;
               smp_in[2] = req_ch2_value;
               for (int c = 0; c < CHANNEL_COUNT; c++) rsp_map_in[c] = 8'd0;
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     state_in   = ST_CLEAR;
                     idx_in     = '0;
                     clr_rsp_in = 1'b1;
                     total_in   = '0;
                     sum_in     = '0;
                     ready_in   = 1'b0;
                  end
                  CMD_COUNT: begin
                     if (total_ff == COUNT_MAX) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_FULL;
                     end else begin
                        state_in = ST_CNT_RD;
                     end
                  end
                  CMD_FINALIZE: begin
                     if (total_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        state_in = ST_FIN_RD;
                        idx_in   = '0;
                        ch_in    = '0;
                        sum_in   = '0;
                     end
                  end
                  CMD_MAP: begin
                     if (!ready_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_NOT_READY;
                     end else begin
                        state_in = ST_MAP_RD;
                     end
                  end
               endcase
            end
         end
         ST_CNT_RD: state_in = ST_CNT_WR;
         ST_CNT_WR: begin
            for (int c = 0; c < CHANNEL_COUNT; c++) bin_we[c] = 1'b1;
            total_in      = total_ff + COUNT_BITS'(1);
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STS_OK;
         end
         ST_MAP_RD: state_in = ST_MAP_OUT;
         ST_MAP_OUT: begin
            rsp_map_in    = map_rd_ff;
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STS_OK;
         end
         ST_FIN_RD: state_in = ST_FIN_ACC;
         ST_FIN_ACC: begin
            // running sum never exceeds the pixel total, so no wrap
            sum_in    = sum_ff + bin_rd_ff[ch_ff];
            div_start = 1'b1;
            state_in  = ST_FIN_DIV;
         end
         ST_FIN_DIV: begin
            if (div_done) begin
               for (int c = 0; c < CHANNEL_COUNT; c++)
                  map_we[c] = (ch_ff == CH_BITS'(c));
               idx_in   = idx_ff + BIN_BITS'(1);
               state_in = ST_FIN_RD;
               if (idx_ff == BIN_LAST) begin
                  if (ch_ff == CH_LAST) begin
                     ready_in      = 1'b1;
                     state_in      = ST_IDLE;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STS_OK;
                  end else begin
                     ch_in  = ch_ff + CH_BITS'(1);
                     sum_in = '0;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      sum_ff        <= sum_in;
      smp_ff        <= smp_in;
      rsp_map_ff    <= rsp_map_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         // reset runs a clearing pass with no response
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         total_ff     <= '0;
         ready_ff     <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         ready_ff     <= ready_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Memories: one write and one registered read per channel per cycle
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         if (bin_we[c]) bin_mem[c][wr_addr[c]] <= bin_wd[c];
         if (map_we[c]) map_mem[c][wr_addr[c]] <= map_wd;
         bin_rd_ff[c] <= bin_mem[c][rd_addr[c]];
         map_rd_ff[c] <= map_mem[c][rd_addr[c]];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ch0_mapped = rsp_map_ff[0];
   assign rsp_ch1_mapped = rsp_map_ff[1];
   assign rsp_ch2_mapped = rsp_map_ff[2];
   assign rsp_status     = rsp_status_ff;

   a_fin_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN_ACC) |-> (total_ff != '0)) else $error("finalize with zero total");
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN_DIV) |-> (sum_ff <= total_ff)) else $error("running sum over total");
   a_ready_after_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(ready_ff) |-> ($past(state_ff) == ST_FIN_DIV) && rsp_valid_ff)
      else $error("tables marked ready outside finalize");

endmodule

/* test/histogram_equalizer_three_channel_tb.sv */
// Testbench for histogram_equalizer_three_channel: count, finalize, map and clear words
// checked against an in-bench equalizer predictor. Depends on heq_pkg and the RTL top.
`timescale 1ns / 100ps

module histogram_equalizer_three_channel_tb;
   import heq_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int QUIET_TAIL  = 150;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] s0;
      logic [7:0] s1;
      logic [7:0] s2;
   } pixel_word_type;

   typedef struct packed {
      logic [7:0] m0;
      logic [7:0] m1;
      logic [7:0] m2;
      status_type sts;
   } mapped_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_command = CMD_CLEAR;
   logic [7:0] req_ch0_value = '0;
   logic [7:0] req_ch1_value = '0;
   logic [7:0] req_ch2_value = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_ch0_mapped;
   logic [7:0] rsp_ch1_mapped;
   logic [7:0] rsp_ch2_mapped;
   logic [1:0] rsp_status;

   histogram_equalizer_three_channel dut (.*);

   always #5 clock = ~clock;

   // Equalizer shadow state
   int unsigned    hist [3][256];
   logic [7:0]     lut [3][256];
   int unsigned    pixels_seen;
   bit             lut_valid;

   pixel_word_type  pending_words [$];
   mapped_word_type expected_maps [$];
   int             failures;
   int             cycles;
   int             n_clear, n_count, n_final, n_map, n_checked;
   bit             quiet;

   function automatic logic [7:0] round_scale(int unsigned cum, int unsigned total);
      longint unsigned num, q, r;
      num = longint'(cum) * 255;
      q = num / total;
      r = num % total;
      // round half to even
      if (2 * r > total || (2 * r == total && q[0])) q++;
      if (q > 255) q = 255;
      return q[7:0];
   endfunction

   // Advance the shadow state by one accepted word and return its expected result.
   function automatic mapped_word_type equalize_word(pixel_word_type w);
      mapped_word_type e;
      int unsigned cum;
      logic [7:0] smp [3];
      e = '{8'd0, 8'd0, 8'd0, STS_OK};
      smp[0] = w.s0; smp[1] = w.s1; smp[2] = w.s2;
      case (w.cmd)
         CMD_CLEAR: begin
            foreach (hist[c, b]) begin
               hist[c][b] = 0;
               lut[c][b] = 0;
            end
            pixels_seen = 0;
            lut_valid = 0;
         end
         CMD_COUNT: begin
            if (pixels_seen >= COUNT_MAX) e.sts = STS_FULL;
            else begin
               for (int c = 0; c < 3; c++) hist[c][smp[c]]++;
               pixels_seen++;
            end
         end
         CMD_FINALIZE: begin
            if (pixels_seen == 0) e.sts = STS_EMPTY;
            else begin
               for (int c = 0; c < 3; c++) begin
                  cum = 0;
                  for (int b = 0; b < 256; b++) begin
                     cum += hist[c][b];
                     lut[c][b] = round_scale(cum, pixels_seen);
                  end
               end
               lut_valid = 1;
            end
         end
         default: begin
            if (!lut_valid) e.sts = STS_NOT_READY;
            else begin
               e.m0 = lut[0][w.s0];
               e.m1 = lut[1][w.s1];
               e.m2 = lut[2][w.s2];
            end
         end
      endcase
      return e;
   endfunction

   function automatic void push_word(cmd_type c, logic [7:0] a, logic [7:0] b,
                                     logic [7:0] d);
      pending_words.push_back('{c, a, b, d});
   endfunction

   // Sample clustered around a center so histograms have shape, not just noise.
   function automatic logic [7:0] clustered(int center, int spread);
      int v;
      v = center + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   // Driver: hold the word while stalled, advance on acceptance, idle in bursts.
   int req_gap = 0;
   always @(posedge clock) begin
      pixel_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_maps.push_back(equalize_word('{cmd_type'(req_command), req_ch0_value,
                                                   req_ch1_value, req_ch2_value}));
            case (cmd_type'(req_command))
               CMD_CLEAR:    n_clear++;
               CMD_COUNT:    n_count++;
               CMD_FINALIZE: n_final++;
               default:      n_map++;
            endcase
         end
         quiet = pending_words.size() < QUIET_TAIL;
         if (req_gap == 0 && !quiet && $urandom_range(0, 15) == 0)
            req_gap = $urandom_range(1, 8);
         if (req_gap > 0 || pending_words.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_valid <= 1'b0;
         end else begin
            nxt = pending_words.pop_front();
            req_valid     <= 1'b1;
            req_command   <= nxt.cmd;
            req_ch0_value <= nxt.s0;
            req_ch1_value <= nxt.s1;
            req_ch2_value <= nxt.s2;
         end
      end
   end

   // Monitor: compare each taken result word with the oldest expectation; stall in bursts.
   int rsp_gap = 0;
   always @(posedge clock) begin
      mapped_word_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_maps.size() == 0) begin
               $error("result word with nothing expected");
               failures++;
            end else begin
               e = expected_maps.pop_front();
               n_checked++;
               if (rsp_ch0_mapped !== e.m0) begin
                  $error("ch0_mapped expected %0d got %0d", e.m0, rsp_ch0_mapped);
                  failures++;
               end
               if (rsp_ch1_mapped !== e.m1) begin
                  $error("ch1_mapped expected %0d got %0d", e.m1, rsp_ch1_mapped);
                  failures++;
               end
               if (rsp_ch2_mapped !== e.m2) begin
                  $error("ch2_mapped expected %0d got %0d", e.m2, rsp_ch2_mapped);
                  failures++;
               end
               if (rsp_status !== e.sts) begin
                  $error("status expected %0d got %0d", e.sts, rsp_status);
                  failures++;
               end
            end
         end
         if (rsp_gap == 0 && !quiet && $urandom_range(0, 11) == 0)
            rsp_gap = $urandom_range(1, 8);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: finalize words dominate the run time.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("histogram_equalizer_three_channel verification failed");
         $finish;
      end
   end

   initial begin
      int n_items, burst, center, spread;
      pixels_seen = 0;
      lut_valid = 0;
      foreach (hist[c, b]) begin
         hist[c][b] = 0;
         lut[c][b] = 0;
      end

      // Directed: map before finalize, finalize with no pixels, sample extremes,
      // count after finalize keeps old tables, map after clear.
      push_word(CMD_MAP,      8'd0,   8'd255, 8'd128);
      push_word(CMD_FINALIZE, 8'd0,   8'd0,   8'd0);
      push_word(CMD_COUNT,    8'd0,   8'd0,   8'd0);
      push_word(CMD_COUNT,    8'd255, 8'd255, 8'd255);
      push_word(CMD_COUNT,    8'd0,   8'd255, 8'd1);
      push_word(CMD_COUNT,    8'd127, 8'd128, 8'd254);
      push_word(CMD_FINALIZE, 8'hFF,  8'hAA,  8'h55);
      push_word(CMD_MAP,      8'd0,   8'd0,   8'd0);
      push_word(CMD_MAP,      8'd255, 8'd255, 8'd255);
      push_word(CMD_MAP,      8'd127, 8'd128, 8'd254);
      push_word(CMD_MAP,      8'd100, 8'd1,   8'd200);
      push_word(CMD_COUNT,    8'd200, 8'd200, 8'd200);
      push_word(CMD_MAP,      8'd200, 8'd200, 8'd200);
      push_word(CMD_FINALIZE, 8'd0,   8'd0,   8'd0);
      push_word(CMD_MAP,      8'd200, 8'd0,   8'd255);
      push_word(CMD_CLEAR,    8'hAA,  8'h55,  8'hFF);
      push_word(CMD_MAP,      8'd5,   8'd6,   8'd7);
      push_word(CMD_FINALIZE, 8'd0,   8'd0,   8'd0);

      // Random: mostly clear / count / finalize / map frames, with some noise.
      n_items = pending_words.size();
      while (n_items < 1250) begin
         if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 6);
            repeat (burst) push_word(cmd_type'($urandom_range(0, 3)), 8'($urandom),
                                     8'($urandom), 8'($urandom));
            n_items += burst;
            continue;
         end
         if ($urandom_range(0, 2) != 0) begin
            push_word(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
            n_items++;
         end
         center = $urandom_range(0, 255);
         spread = ($urandom_range(0, 3) == 0) ? 128 : $urandom_range(0, 40);
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 60);
         repeat (burst)
            push_word(CMD_COUNT, clustered(center, spread), clustered(255 - center, spread),
                      8'($urandom));
         push_word(CMD_FINALIZE, 8'($urandom), 8'($urandom), 8'($urandom));
         n_items += burst + 1;
         burst = $urandom_range(10, 40);
         repeat (burst) begin
            if ($urandom_range(0, 7) == 0)
               push_word(CMD_COUNT, 8'($urandom), 8'($urandom), 8'($urandom));
            else
               push_word(CMD_MAP, 8'($urandom), 8'($urandom), 8'($urandom));
         end
         n_items += burst;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("words: %0d clear, %0d count, %0d finalize, %0d map; %0d results checked",
               n_clear, n_count, n_final, n_map, n_checked);
      if (failures == 0 && expected_maps.size() == 0) begin
         $display("histogram_equalizer_three_channel verification clean");
      end else begin
         $display("histogram_equalizer_three_channel verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/heq_pkg.sv
rtl/heq_scale.sv
rtl/histogram_equalizer_three_channel.sv
test/histogram_equalizer_three_channel_tb.sv
